// ===== hdl/irt_pkg.sv =====
// ----------------------------------------------------------------------------
// irt_pkg: shared types and codes for the interval reservation table
// Beat layouts of the request and response channels, request opcodes and
// response status codes.
// ----------------------------------------------------------------------------
package irt_pkg;

   // Width of a time stamp on the request channel.
   localparam int TIME_BITS = 16;
   // Fixed widths of the response fields.
   localparam int SLOT_BITS = 4;
   localparam int USED_BITS = 5;

   // Request opcodes.
   localparam logic [1:0] OP_CHECK = 2'd0;
   localparam logic [1:0] OP_BOOK  = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // Response status codes.
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_OCCUPIED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_BAD      = 2'd3;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [TIME_BITS-1:0] start_time;
      logic [TIME_BITS-1:0] end_time;
   } irt_req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 overlap_found;
      logic [SLOT_BITS-1:0] slot_index;
      logic [USED_BITS-1:0] entries_used;
   } irt_rsp_type;

endpackage

// ===== hdl/irt_ram.sv =====
// ----------------------------------------------------------------------------
// irt_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read enable.
// ----------------------------------------------------------------------------
module irt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/interval_reservation_table.sv =====
// ----------------------------------------------------------------------------
// interval_reservation_table: table of booked half-open time intervals
// Checks, books, frees and clears intervals [start, end) kept in a RAM.
// ----------------------------------------------------------------------------
// A request beat enters on req_valid/req_ready and carries an opcode with a
// start and end time. Exactly one response beat leaves on rsp_valid/rsp_ready
// for every request, in request order.
// The interval bounds live in one RAM with a registered read, and the
// per-slot valid bits and the use count live in flip-flops. Every request
// except clear and a malformed range walks the slots in ascending order: a
// valid slot is read in ST_SCAN, then evaluated and written back in
// ST_EVAL; an empty slot is stepped over in ST_SCAN. A book, or a split
// during a free, then searches the valid bits for the lowest empty slot
// at one slot per cycle. Clear and a malformed range skip the walk and
// go straight to the reply.
// Requests are handled one at a time: req_ready is high only while the
// engine is idle. The response sits in an output register, so the next
// request is taken while a response is still waiting; if that request
// finishes before the receiver takes the old response, it waits.
// Reset empties the table and drops any pending response; the RAM needs
// no clearing pass since only slots marked valid are ever read.
// ----------------------------------------------------------------------------
module interval_reservation_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  irt_pkg::irt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output irt_pkg::irt_rsp_type rsp_data
);

   import irt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ENT_W = 2 * TIME_BITS;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_EVAL  = 6'b000100,
      ST_FIND  = 6'b001000,
      ST_WRAP  = 6'b010000,
      ST_REPLY = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [1:0]             op_ff, op_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;
   logic [TIME_BITS-1:0]   end_ff, end_in;
   logic [TIME_BITS-1:0]   split_end_ff, split_end_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       fidx_ff, fidx_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   ovl_ff, ovl_in;
   logic [1:0]             status_ff, status_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   irt_rsp_type            rsp_ff, rsp_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [ENT_W-1:0]       ram_wdata;
   logic                   ram_re;
   logic [ENT_W-1:0]       ram_rdata;

   logic [TIME_BITS-1:0]   ent_start;
   logic [TIME_BITS-1:0]   ent_end;
   logic                   hit;
   logic                   covered;
   logic                   inner;
   logic                   table_full;
   logic                   last_idx;
   logic                   step;

   // Each RAM word holds {start, end} of one slot.
   irt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign ent_start  = ram_rdata[ENT_W-1:TIME_BITS];
   assign ent_end    = ram_rdata[TIME_BITS-1:0];
   // Half-open intervals overlap when each starts before the other ends.
   assign hit        = (start_ff < ent_end) && (ent_start < end_ff);
   assign covered    = (start_ff <= ent_start) && (ent_end <= end_ff);
   assign inner      = (ent_start < start_ff) && (end_ff < ent_end);
   assign table_full = (used_ff == CNT_W'(TABLE_DEPTH));
   assign last_idx   = (idx_ff == IDX_W'(TABLE_DEPTH - 1));

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      split_end_in = split_end_ff;
      idx_in       = idx_ff;
      fidx_in      = fidx_ff;
      slot_in      = slot_ff;
      ovl_in       = ovl_ff;
      status_in    = status_ff;
      valid_in     = valid_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = {start_ff, end_ff};
      ram_re       = 1'b0;
      step         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.req_type;
               start_in  = req_data.start_time;
               end_in    = req_data.end_time;
               idx_in    = '0;
               slot_in   = '0;
               ovl_in    = 1'b0;
               status_in = STATUS_DONE;
               if (req_data.req_type == OP_CLEAR) begin
                  valid_in = '0;
                  used_in  = '0;
                  state_in = ST_REPLY;
               end else if (req_data.start_time >= req_data.end_time) begin
                  status_in = STATUS_BAD;
                  state_in  = ST_REPLY;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Only valid slots are read; empty ones are skipped.
            if (valid_ff[idx_ff]) begin
               ram_re   = 1'b1;
               state_in = ST_EVAL;
            end else begin
               step = 1'b1;
            end
         end

         ST_EVAL: begin
            step = 1'b1;
            if (hit) begin
               ovl_in = 1'b1;
               if (op_ff == OP_FREE) begin
                  if (covered) begin
                     valid_in[idx_ff] = 1'b0;
                     used_in          = used_ff - CNT_W'(1);
                  end else if (inner) begin
                     // Split: keep the left part here, the right part goes
                     // to the lowest empty slot, if there is one.
                     if (table_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ram_we       = 1'b1;
                        ram_wdata    = {ent_start, start_ff};
                        split_end_in = ent_end;
                        fidx_in      = '0;
                        state_in     = ST_FIND;
                        step         = 1'b0;
                     end
                  end else if (ent_start < start_ff) begin
                     ram_we    = 1'b1;
                     ram_wdata = {ent_start, start_ff};
                  end else begin
                     ram_we    = 1'b1;
                     ram_wdata = {end_ff, ent_end};
                  end
               end
            end
         end

         ST_FIND: begin
            // The table is known not to be full, so an empty slot exists.
            if (!valid_ff[fidx_ff]) begin
               ram_we            = 1'b1;
               ram_waddr         = fidx_ff;
               valid_in[fidx_ff] = 1'b1;
               used_in           = used_ff + CNT_W'(1);
               if (op_ff == OP_BOOK) begin
                  ram_wdata = {start_ff, end_ff};
                  slot_in   = fidx_ff;
                  state_in  = ST_REPLY;
               end else begin
                  ram_wdata = {end_ff, split_end_ff};
                  step      = 1'b1;
               end
            end else begin
               fidx_in = fidx_ff + IDX_W'(1);
            end
         end

         ST_WRAP: begin
            state_in = ST_REPLY;
            if (op_ff == OP_BOOK) begin
               if (ovl_ff) begin
                  status_in = STATUS_OCCUPIED;
               end else if (table_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  fidx_in  = '0;
                  state_in = ST_FIND;
               end
            end else if (op_ff == OP_CHECK) begin
               status_in = ovl_ff ? STATUS_OCCUPIED : STATUS_DONE;
            end
         end

         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.overlap_found = ovl_ff;
               rsp_in.slot_index    = SLOT_BITS'(slot_ff);
               rsp_in.entries_used  = USED_BITS'(used_ff);
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move on to the next slot, or finish once the last one is done.
      if (step) begin
         if (last_idx) begin
            state_in = ST_WRAP;
         end else begin
            idx_in   = idx_ff + IDX_W'(1);
            state_in = ST_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      split_end_ff <= split_end_in;
      idx_ff       <= idx_in;
      fidx_ff      <= fidx_in;
      slot_ff      <= slot_in;
      ovl_ff       <= ovl_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

endmodule
